// ===== sv/pbwfs_pkg.sv =====
// Shared types and constants for the protobuf wire field scanner.
// No dependencies; imported by protobuf_wire_field_scanner.
package pbwfs_pkg;

  // Result queue sizing
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // Varint groups kept before further groups are dropped
  localparam logic [3:0] MaxGroups = 4'd10;

  // Record kinds
  localparam logic [1:0] KIND_VARINT  = 2'd0;
  localparam logic [1:0] KIND_LEN_HDR = 2'd1;
  localparam logic [1:0] KIND_PAYLOAD = 2'd2;
  localparam logic [1:0] KIND_END     = 2'd3;

  // End status codes
  localparam logic [1:0] STAT_CLEAN     = 2'd0;
  localparam logic [1:0] STAT_ZERO_TAG  = 2'd1;
  localparam logic [1:0] STAT_TRUNCATED = 2'd2;
  localparam logic [1:0] STAT_BAD_WIRE  = 2'd3;

  // Wire types
  localparam logic [2:0] WT_VARINT  = 3'd0;
  localparam logic [2:0] WT_FIXED64 = 3'd1;
  localparam logic [2:0] WT_LEN     = 3'd2;
  localparam logic [2:0] WT_FIXED32 = 3'd5;

  // One result record
  typedef struct packed {
    logic [1:0]  record_kind;
    logic [31:0] field_number;
    logic [2:0]  wire_type;
    logic [63:0] field_value;
    logic [7:0]  payload_byte;
    logic [1:0]  end_status;
    logic        last_record;
  } rec_t;

endpackage

// ===== sv/protobuf_wire_field_scanner.sv =====
// Protobuf wire-format field scanner: byte-wide decoder with a four-entry result queue.
// Depends on pbwfs_pkg.

// Takes one message byte per cycle while in_ready_o is high (end_of_message_i on the
// final byte) and emits records: a value record per varint field, a header plus one
// record per payload byte for length-delimited fields, nothing for fixed32/fixed64
// fields, and a status record closing every message. A zero tag or a bad wire type
// stops decoding until the message end; a message cut inside a field ends truncated.
// A byte is decoded in the cycle it is accepted; the parser state is registered at the
// end of that cycle. Records leave through a four-entry queue at one per cycle while
// out_ready_i is high; in_ready_o is high while at least two entries are free, so a
// byte that yields both a data and a status record always finds room for both.
module protobuf_wire_field_scanner
  import pbwfs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  in_byte_i,
  input  logic        end_of_message_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  record_kind_o,
  output logic [31:0] field_number_o,
  output logic [2:0]  wire_type_o,
  output logic [63:0] field_value_o,
  output logic [7:0]  payload_byte_o,
  output logic [1:0]  end_status_o,
  output logic        last_record_o
);

  typedef enum logic [2:0] {
    PH_TAG     = 3'd0,
    PH_VALUE   = 3'd1,
    PH_LEN     = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_SKIP    = 3'd4,
    PH_STOPPED = 3'd5
  } phase_e;

  // Place a 7-bit group at its position in the 64-bit value
  function automatic logic [63:0] group_shift(logic [6:0] grp, logic [3:0] idx);
    logic [70:0] wide;
    wide = {64'd0, grp} << ({3'd0, idx} * 7'd7);
    return wide[63:0];
  endfunction

  phase_e      phase_q, phase_d;
  logic [63:0] acc_q, acc_d;
  logic [3:0]  gc_q, gc_d;
  logic [31:0] fld_q, fld_d;
  logic [2:0]  wire_q, wire_d;
  logic [63:0] brem_q, brem_d;
  logic [1:0]  stop_q, stop_d;

  rec_t             queue_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q;

  logic        in_acc, out_acc;
  logic        data_v, stat_v;
  rec_t        data_rec, stat_rec;
  logic [63:0] acc_upd;
  logic [3:0]  gc_upd;
  logic        vdone;
  logic [1:0]  push_n;

  assign in_ready_o  = (cnt_q <= QCntW'(QDepth - 2));
  assign in_acc      = in_valid_i & in_ready_o;
  assign out_valid_o = (cnt_q != '0);
  assign out_acc     = out_valid_o & out_ready_i;

  // Varint group accumulation, saturating at ten groups
  assign acc_upd = (gc_q < MaxGroups) ? (acc_q | group_shift(in_byte_i[6:0], gc_q)) : acc_q;
  assign gc_upd  = (gc_q < MaxGroups) ? gc_q + 4'd1 : gc_q;
  assign vdone   = ~in_byte_i[7];

  // Decode one byte: next parser state and up to two records
  always_comb begin
    phase_d  = phase_q;
    acc_d    = acc_q;
    gc_d     = gc_q;
    fld_d    = fld_q;
    wire_d   = wire_q;
    brem_d   = brem_q;
    stop_d   = stop_q;
    data_v   = 1'b0;
    data_rec = '0;
    stat_v   = 1'b0;
    stat_rec = '0;
    if (in_acc) begin
      case (phase_q)
        PH_STOPPED: begin
        end
        PH_VALUE: begin
          if (vdone) begin
            data_v                = 1'b1;
            data_rec.record_kind  = KIND_VARINT;
            data_rec.field_number = fld_q;
            data_rec.wire_type    = wire_q;
            data_rec.field_value  = acc_upd;
            acc_d                 = '0;
            gc_d                  = '0;
            phase_d               = PH_TAG;
          end else begin
            acc_d = acc_upd;
            gc_d  = gc_upd;
          end
        end
        PH_LEN: begin
          if (vdone) begin
            data_v                = 1'b1;
            data_rec.record_kind  = KIND_LEN_HDR;
            data_rec.field_number = fld_q;
            data_rec.wire_type    = wire_q;
            data_rec.field_value  = acc_upd;
            acc_d                 = '0;
            gc_d                  = '0;
            if (acc_upd == '0) begin
              phase_d = PH_TAG;
            end else begin
              brem_d  = acc_upd;
              phase_d = PH_PAYLOAD;
            end
          end else begin
            acc_d = acc_upd;
            gc_d  = gc_upd;
          end
        end
        PH_PAYLOAD: begin
          data_v                = 1'b1;
          data_rec.record_kind  = KIND_PAYLOAD;
          data_rec.field_number = fld_q;
          data_rec.wire_type    = wire_q;
          data_rec.payload_byte = in_byte_i;
          brem_d                = brem_q - 64'd1;
          if (brem_q == 64'd1) begin
            phase_d = PH_TAG;
          end
        end
        PH_SKIP: begin
          brem_d = brem_q - 64'd1;
          if (brem_q == 64'd1) begin
            phase_d = PH_TAG;
          end
        end
        default: begin
          // tag byte (unused phase codes behave the same)
          if (vdone) begin
            acc_d = '0;
            gc_d  = '0;
            if (acc_upd == '0) begin
              phase_d = PH_STOPPED;
              stop_d  = STAT_ZERO_TAG;
            end else begin
              fld_d  = acc_upd[34:3];
              wire_d = acc_upd[2:0];
              case (acc_upd[2:0])
                WT_VARINT:  phase_d = PH_VALUE;
                WT_LEN:     phase_d = PH_LEN;
                WT_FIXED64: begin
                  brem_d  = 64'd8;
                  phase_d = PH_SKIP;
                end
                WT_FIXED32: begin
                  brem_d  = 64'd4;
                  phase_d = PH_SKIP;
                end
                default: begin
                  phase_d = PH_STOPPED;
                  stop_d  = STAT_BAD_WIRE;
                end
              endcase
            end
          end else begin
            acc_d   = acc_upd;
            gc_d    = gc_upd;
            phase_d = PH_TAG;
          end
        end
      endcase

      // message end: status record, then back to the reset state
      if (end_of_message_i) begin
        stat_v               = 1'b1;
        stat_rec.record_kind = KIND_END;
        stat_rec.last_record = 1'b1;
        if (phase_d == PH_STOPPED) begin
          stat_rec.end_status = stop_d;
        end else if (phase_d == PH_TAG && gc_d == '0) begin
          stat_rec.end_status = STAT_CLEAN;
        end else begin
          stat_rec.end_status = STAT_TRUNCATED;
        end
        phase_d = PH_TAG;
        acc_d   = '0;
        gc_d    = '0;
        fld_d   = '0;
        wire_d  = '0;
        brem_d  = '0;
        stop_d  = '0;
      end
    end
  end

  assign push_n = {1'b0, data_v} + {1'b0, stat_v};

  // Parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_TAG;
      acc_q   <= '0;
      gc_q    <= '0;
      fld_q   <= '0;
      wire_q  <= '0;
      brem_q  <= '0;
      stop_q  <= '0;
    end else begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
      gc_q    <= gc_d;
      fld_q   <= fld_d;
      wire_q  <= wire_d;
      brem_q  <= brem_d;
      stop_q  <= stop_d;
    end
  end

  // Result queue pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + QPtrW'(push_n);
      if (out_acc) begin
        rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      end
      cnt_q <= cnt_q + QCntW'(push_n) - QCntW'(out_acc);
    end
  end

  // Result queue storage; status beat lands after the data beat
  always_ff @(posedge clk_i) begin
    if (data_v) begin
      queue_q[wr_ptr_q] <= data_rec;
    end
    if (stat_v) begin
      queue_q[wr_ptr_q + QPtrW'(data_v)] <= stat_rec;
    end
  end

  assign record_kind_o  = queue_q[rd_ptr_q].record_kind;
  assign field_number_o = queue_q[rd_ptr_q].field_number;
  assign wire_type_o    = queue_q[rd_ptr_q].wire_type;
  assign field_value_o  = queue_q[rd_ptr_q].field_value;
  assign payload_byte_o = queue_q[rd_ptr_q].payload_byte;
  assign end_status_o   = queue_q[rd_ptr_q].end_status;
  assign last_record_o  = queue_q[rd_ptr_q].last_record;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCntW'(QDepth))
    else $error("result queue overfilled");

  a_gc_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gc_q <= MaxGroups)
    else $error("varint group count past saturation");

  a_eom_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && end_of_message_i) |=> (phase_q == PH_TAG && gc_q == '0 && acc_q == '0))
    else $error("parser not cleared after message end");

  a_payload_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_PAYLOAD || phase_q == PH_SKIP) |-> (brem_q != '0))
    else $error("byte phase with nothing remaining");

  a_ptr_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_ptr_q == (rd_ptr_q + cnt_q[QPtrW-1:0]))
    else $error("queue pointers disagree with fill count");
`endif

endmodule

// ===== dv/protobuf_wire_field_scanner_test.sv =====
`timescale 1ns / 100ps
// Self-checking bench for protobuf_wire_field_scanner: byte beats in, decoded records out.
// A built-in scanner predicts every record; directed then random messages with random stalls.
// Depends on pbwfs_pkg and protobuf_wire_field_scanner.
module protobuf_wire_field_scanner_test;
  import pbwfs_pkg::*;

  // Scanner phases of the predictor
  typedef enum logic [2:0] {
    SCAN_TAG, SCAN_VALUE, SCAN_LENGTH, SCAN_PAYLOAD, SCAN_SKIP, SCAN_HALTED
  } scan_phase_e;

  // Wire types that stop decoding
  localparam logic [2:0] WT_GROUP_START = 3'd3;
  localparam logic [2:0] WT_GROUP_END   = 3'd4;
  localparam logic [2:0] WT_RESERVED6   = 3'd6;
  localparam logic [2:0] WT_RESERVED7   = 3'd7;

  localparam logic [63:0] FIXED32_BYTES = 64'd4;
  localparam logic [63:0] FIXED64_BYTES = 64'd8;
  localparam int          TARGET_BEATS  = 1300;
  localparam int          IDLE_PERCENT  = 38;
  localparam int          CALM_FROM     = 600;
  localparam int          CALM_TO       = 850;

  typedef struct packed {
    logic [7:0] data;
    logic       eom;
  } wire_beat_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  in_byte_i = 8'h00;
  logic        end_of_message_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  record_kind_o;
  logic [31:0] field_number_o;
  logic [2:0]  wire_type_o;
  logic [63:0] field_value_o;
  logic [7:0]  payload_byte_o;
  logic [1:0]  end_status_o;
  logic        last_record_o;

  protobuf_wire_field_scanner DUT (.*);

  always #4 clk_i = ~clk_i;

  wire_beat_t beat_queue[$];
  logic [7:0] msg_bytes[$];
  rec_t       pending_records[$];

  int errors = 0;
  int beats_taken = 0;
  int records_checked = 0;
  int messages_built = 0;
  int status_seen[4] = '{0, 0, 0, 0};

  // Predictor state
  scan_phase_e phase = SCAN_TAG;
  logic [63:0] acc_value = '0;
  logic [3:0]  acc_groups = '0;
  logic [31:0] cur_field = '0;
  logic [2:0]  cur_wire = '0;
  logic [63:0] left_bytes = '0;
  logic [1:0]  halt_code = STAT_CLEAN;

  function automatic void clear_scanner();
    phase      = SCAN_TAG;
    acc_value  = '0;
    acc_groups = '0;
    cur_field  = '0;
    cur_wire   = '0;
    left_bytes = '0;
    halt_code  = STAT_CLEAN;
  endfunction

  // Folds one 7-bit group in; groups past the tenth are dropped. 1 on the closing group.
  function automatic bit take_group(logic [7:0] b);
    if (acc_groups < MaxGroups) begin
      acc_value  = acc_value | ({57'd0, b[6:0]} << (7 * acc_groups));
      acc_groups = acc_groups + 4'd1;
    end
    return !b[7];
  endfunction

  function automatic void post_record(logic [1:0] kind, logic [31:0] fnum, logic [2:0] wt,
                                      logic [63:0] value, logic [7:0] pbyte,
                                      logic [1:0] status, logic last);
    rec_t r;
    r.record_kind  = kind;
    r.field_number = fnum;
    r.wire_type    = wt;
    r.field_value  = value;
    r.payload_byte = pbyte;
    r.end_status   = status;
    r.last_record  = last;
    pending_records = {pending_records, r};
  endfunction

  // Advances the predicted scanner by one accepted beat
  function automatic void scan_byte(logic [7:0] b, logic eom);
    logic [63:0] v;
    logic [1:0]  code;
    case (phase)
      SCAN_HALTED: ;
      SCAN_VALUE: begin
        if (take_group(b)) begin
          v = acc_value;
          acc_value = '0;
          acc_groups = '0;
          post_record(KIND_VARINT, cur_field, WT_VARINT, v, 8'h00, STAT_CLEAN, 1'b0);
          phase = SCAN_TAG;
        end
      end
      SCAN_LENGTH: begin
        if (take_group(b)) begin
          v = acc_value;
          acc_value = '0;
          acc_groups = '0;
          post_record(KIND_LEN_HDR, cur_field, WT_LEN, v, 8'h00, STAT_CLEAN, 1'b0);
          if (v == 64'd0) begin
            phase = SCAN_TAG;
          end else begin
            left_bytes = v;
            phase = SCAN_PAYLOAD;
          end
        end
      end
      SCAN_PAYLOAD: begin
        post_record(KIND_PAYLOAD, cur_field, WT_LEN, 64'd0, b, STAT_CLEAN, 1'b0);
        left_bytes = left_bytes - 64'd1;
        if (left_bytes == 64'd0) phase = SCAN_TAG;
      end
      SCAN_SKIP: begin
        left_bytes = left_bytes - 64'd1;
        if (left_bytes == 64'd0) phase = SCAN_TAG;
      end
      default: begin
        if (take_group(b)) begin
          v = acc_value;
          acc_value = '0;
          acc_groups = '0;
          if (v == 64'd0) begin
            phase = SCAN_HALTED;
            halt_code = STAT_ZERO_TAG;
          end else begin
            cur_field = v[34:3];
            cur_wire  = v[2:0];
            case (cur_wire)
              WT_VARINT: phase = SCAN_VALUE;
              WT_LEN:    phase = SCAN_LENGTH;
              WT_FIXED64: begin
                left_bytes = FIXED64_BYTES;
                phase = SCAN_SKIP;
              end
              WT_FIXED32: begin
                left_bytes = FIXED32_BYTES;
                phase = SCAN_SKIP;
              end
              default: begin
                phase = SCAN_HALTED;
                halt_code = STAT_BAD_WIRE;
              end
            endcase
          end
        end
      end
    endcase

    // Closing status; the scanner starts afresh for the next message
    if (eom) begin
      if (phase == SCAN_HALTED) code = halt_code;
      else if (phase == SCAN_TAG && acc_groups == 4'd0) code = STAT_CLEAN;
      else code = STAT_TRUNCATED;
      post_record(KIND_END, 32'd0, WT_VARINT, 64'd0, 8'h00, code, 1'b1);
      clear_scanner();
    end
  endfunction

  function automatic void compare_field(string what, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      errors++;
      if (errors <= 40)
        $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, what, want, got);
    end
  endfunction

  // Checks one output beat against the oldest predicted record
  function automatic void check_record();
    rec_t want;
    if (pending_records.size() == 0) begin
      errors++;
      if (errors <= 40)
        $display("%0t ns: unexpected record, expected none, actual kind %0d status %0d",
                 $time, record_kind_o, end_status_o);
      return;
    end
    want = pending_records.pop_front();
    records_checked++;
    if (want.record_kind == KIND_END) status_seen[want.end_status]++;
    compare_field("record_kind", 64'(want.record_kind), 64'(record_kind_o));
    compare_field("field_number", 64'(want.field_number), 64'(field_number_o));
    compare_field("wire_type", 64'(want.wire_type), 64'(wire_type_o));
    compare_field("field_value", want.field_value, field_value_o);
    compare_field("payload_byte", 64'(want.payload_byte), 64'(payload_byte_o));
    compare_field("end_status", 64'(want.end_status), 64'(end_status_o));
    compare_field("last_record", 64'(want.last_record), 64'(last_record_o));
  endfunction

  // Random idling, switched off over a stretch in the middle of the run
  function automatic bit hold_off();
    if (beats_taken >= CALM_FROM && beats_taken < CALM_TO) return 1'b0;
    return $urandom_range(0, 99) < IDLE_PERCENT;
  endfunction

  // Driver: next beat once the current one is taken
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i       <= 1'b0;
      in_byte_i        <= 8'h00;
      end_of_message_i <= 1'b0;
    end else if (!in_valid_i || in_ready_o) begin
      if (beat_queue.size() != 0 && !hold_off()) begin
        in_valid_i       <= 1'b1;
        in_byte_i        <= beat_queue[0].data;
        end_of_message_i <= beat_queue[0].eom;
        void'(beat_queue.pop_front());
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Monitor: predict on input beats, check output beats, stall the output side
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        scan_byte(in_byte_i, end_of_message_i);
        beats_taken++;
      end
      if (out_valid_o && out_ready_i) check_record();
      out_ready_i <= !hold_off();
    end
  end

  // ---- Message building ----

  function automatic bit stretch();
    return $urandom_range(0, 9) == 0;
  endfunction

  // Varint encoding; a stretched one carries redundant groups, some past the tenth
  function automatic void emit_varint(logic [63:0] v, bit pad);
    int n;
    int total;
    logic [63:0] sh;
    logic [7:0] g;
    n = 1;
    while (n < 10 && (v >> (7 * n)) != 64'd0) n++;
    total = pad ? int'($urandom_range(n, 12)) : n;
    for (int i = 0; i < total; i++) begin
      if (i < 10) begin
        sh = v >> (7 * i);
        g[6:0] = sh[6:0];
      end else begin
        g[6:0] = 7'($urandom_range(0, 127));
      end
      // Bits above 64 in the tenth group are dropped
      if (i == 9 && pad) g[6:1] = 6'($urandom_range(0, 63));
      g[7] = (i < total - 1);
      msg_bytes = {msg_bytes, g};
    end
  endfunction

  function automatic void add_junk(int count);
    for (int i = 0; i < count; i++) msg_bytes = {msg_bytes, 8'($urandom_range(0, 255))};
  endfunction

  function automatic logic [63:0] wide_value();
    logic [63:0] v;
    if ($urandom_range(0, 19) == 0) return '1;
    v = {$urandom, $urandom};
    return v >> $urandom_range(0, 63);
  endfunction

  function automatic void emit_tag(logic [2:0] wt);
    logic [31:0] fnum;
    logic [28:0] hi;
    case ($urandom_range(0, 3))
      0:       fnum = $urandom_range(1, 15);
      1:       fnum = $urandom_range(0, 2047);
      2:       fnum = $urandom;
      default: fnum = '1;
    endcase
    hi = (stretch()) ? 29'($urandom) : 29'd0;
    emit_varint({hi, fnum, wt}, stretch());
  endfunction

  // One field; 1 when the message should end after it
  function automatic bit add_field();
    int pick;
    int len;
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      emit_tag(WT_VARINT);
      emit_varint(wide_value(), stretch());
    end else if (pick < 62) begin
      emit_tag(WT_LEN);
      if ($urandom_range(0, 19) == 0) begin
        // length running past the message end
        emit_varint(wide_value() | 64'h80, stretch());
        add_junk($urandom_range(0, 6));
        return 1'b1;
      end
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 40) : $urandom_range(0, 5);
      emit_varint(64'(len), stretch());
      add_junk(len);
    end else if (pick < 72) begin
      emit_tag(WT_FIXED32);
      add_junk(int'(FIXED32_BYTES));
    end else if (pick < 82) begin
      emit_tag(WT_FIXED64);
      add_junk(int'(FIXED64_BYTES));
    end else if (pick < 92) begin
      case ($urandom_range(0, 3))
        0:       emit_tag(WT_GROUP_START);
        1:       emit_tag(WT_GROUP_END);
        2:       emit_tag(WT_RESERVED6);
        default: emit_tag(WT_RESERVED7);
      endcase
      add_junk($urandom_range(0, 4));
      return 1'b1;
    end else begin
      emit_varint(64'd0, stretch());
      add_junk($urandom_range(0, 4));
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Queues the first keep bytes of msg_bytes as one message
  function automatic void send_message(int keep);
    wire_beat_t beat;
    for (int i = 0; i < keep; i++) begin
      beat.data = msg_bytes[i];
      beat.eom  = (i == keep - 1);
      beat_queue = {beat_queue, beat};
    end
    messages_built++;
    msg_bytes.delete();
  endfunction

  function automatic void random_message();
    int nf;
    int keep;
    if ($urandom_range(0, 9) == 0) begin
      add_junk($urandom_range(1, 8));
    end else begin
      nf = $urandom_range(1, 4);
      for (int i = 0; i < nf; i++)
        if (add_field()) break;
    end
    keep = ($urandom_range(0, 4) == 0) ? $urandom_range(1, msg_bytes.size())
                                       : msg_bytes.size();
    send_message(keep);
  endfunction

  // ---- Stimulus and end of run ----
  initial begin
    // field 1 varint 150, value closing on the last byte
    msg_bytes = '{8'h08, 8'h96, 8'h01};
    send_message(msg_bytes.size());
    // zero tag
    msg_bytes = '{8'h00};
    send_message(msg_bytes.size());
    // group-end wire type, then ignored bytes
    msg_bytes = '{8'h0C, 8'hFF, 8'h00};
    send_message(msg_bytes.size());
    // field 2, two payload bytes, last one also ends the message
    msg_bytes = '{8'h12, 8'h02, 8'hAA, 8'h55};
    send_message(msg_bytes.size());
    // empty payload
    msg_bytes = '{8'h1A, 8'h00};
    send_message(msg_bytes.size());
    // fixed32 skipped whole
    msg_bytes = '{8'h0D, 8'h01, 8'h02, 8'h03, 8'h04};
    send_message(msg_bytes.size());
    // fixed64 cut short
    msg_bytes = '{8'h09, 8'h01};
    send_message(msg_bytes.size());
    // varint value cut short
    msg_bytes = '{8'h08, 8'h80};
    send_message(msg_bytes.size());
    // tag cut short
    msg_bytes = '{8'h80};
    send_message(msg_bytes.size());

    while (beat_queue.size() < TARGET_BEATS) random_message();

    repeat (7) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    while (beat_queue.size() != 0 || in_valid_i) @(posedge clk_i);
    while (pending_records.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);

    if (pending_records.size() != 0) begin
      errors++;
      $display("%0t ns: %0d records never arrived", $time, pending_records.size());
    end
    $display("Run covered %0d messages in %0d byte beats; %0d records checked.",
             messages_built, beats_taken, records_checked);
    $display("Message ends: clean %0d, zero tag %0d, truncated %0d, bad wire type %0d.",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
    if (errors == 0) begin
      $display("protobuf_wire_field_scanner test passed");
    end else begin
      $display("protobuf_wire_field_scanner test failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("Timeout with %0d records outstanding", pending_records.size());
    $display("protobuf_wire_field_scanner test failed");
    $finish;
  end

endmodule

// ===== protobuf_wire_field_scanner.f =====
sv/pbwfs_pkg.sv
sv/protobuf_wire_field_scanner.sv
dv/protobuf_wire_field_scanner_test.sv
